[rtl/tlbp_pkg.sv]
// ----------------------------------------------------------------------------
// tlbp_pkg
// Shared types and constants of the two-level branch predictor with BTB.
// ----------------------------------------------------------------------------
package tlbp_pkg;

	localparam int PC_W       = 32;
	localparam int ADDR_LSB   = 2;
	localparam int TAG_W      = PC_W - ADDR_LSB;
	localparam int HLEN_W     = 4;
	localparam int TLEN_W     = 5;
	localparam int CTR_W      = 2;
	localparam int SHARE_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	localparam int DEF_BTB_ENTRIES = 32;
	localparam int DEF_MAX_HISTORY = 8;

	localparam int XOR_LO_BIT = 2;
	localparam int XOR_HI_BIT = 16;
	localparam int PC_STEP    = 4;

	localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;
	localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
	localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;

	localparam logic [SHARE_W-1:0] SHR_OFF   = 2'd0;
	localparam logic [SHARE_W-1:0] SHR_PC_LO = 2'd1;
	localparam logic [SHARE_W-1:0] SHR_PC_HI = 2'd2;

	localparam logic [HLEN_W-1:0]  RST_HIST_LEN     = 4'd8;
	localparam logic [TLEN_W-1:0]  RST_TAG_LEN      = 5'd30;
	localparam logic [CTR_W-1:0]   RST_INIT_CTR     = 2'd1;
	localparam logic               RST_HIST_SHARED  = 1'b0;
	localparam logic               RST_GLOBAL_TABLE = 1'b0;
	localparam logic [SHARE_W-1:0] RST_SHARE_MODE   = SHR_OFF;

	typedef enum logic {
		OP_PREDICT = 1'b0,
		OP_UPDATE  = 1'b1
	} tlbp_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HISTORY_LENGTH   = 3'd0,
		REG_TAG_LENGTH       = 3'd1,
		REG_INITIAL_COUNTER  = 3'd2,
		REG_SHARED_HISTORY   = 3'd3,
		REG_USE_GLOBAL_TABLE = 3'd4,
		REG_SHARE_MODE       = 3'd5
	} tlbp_reg_t;

	typedef struct packed {
		logic [HLEN_W-1:0]  hist_len;
		logic [TLEN_W-1:0]  tag_len;
		logic [CTR_W-1:0]   init_ctr;
		logic               hist_shared;
		logic               global_table;
		logic [SHARE_W-1:0] share_mode;
	} tlbp_cfg_t;

endpackage

[rtl/tlbp_req_if.sv]
// ----------------------------------------------------------------------------
// tlbp_req_if
// Request channel: predict lookups and resolve updates.
// ----------------------------------------------------------------------------
interface tlbp_req_if;

	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [tlbp_pkg::PC_W-1:0]  pc;
	logic [tlbp_pkg::PC_W-1:0]  target_pc;
	logic                       taken;
	logic [tlbp_pkg::PC_W-1:0]  predicted_dest;

	modport source (
		output valid, operation, pc, target_pc, taken, predicted_dest,
		input  ready
	);

	modport sink (
		input  valid, operation, pc, target_pc, taken, predicted_dest,
		output ready
	);

endinterface

[rtl/tlbp_rsp_if.sv]
// ----------------------------------------------------------------------------
// tlbp_rsp_if
// Result channel: prediction and running statistics.
// ----------------------------------------------------------------------------
interface tlbp_rsp_if;

	logic                       valid;
	logic                       ready;
	logic                       predicted_taken;
	logic [tlbp_pkg::PC_W-1:0]  predicted_target;
	logic [tlbp_pkg::PC_W-1:0]  branch_count;
	logic [tlbp_pkg::PC_W-1:0]  flush_count;

	modport source (
		output valid, predicted_taken, predicted_target, branch_count, flush_count,
		input  ready
	);

	modport sink (
		input  valid, predicted_taken, predicted_target, branch_count, flush_count,
		output ready
	);

endinterface

[rtl/tlbp_ram.sv]
// ----------------------------------------------------------------------------
// tlbp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tlbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tlbp_cfg.sv]
// ----------------------------------------------------------------------------
// tlbp_cfg
// Configuration registers; flags a counter refill on every valid write.
// ----------------------------------------------------------------------------
module tlbp_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  logic [tlbp_pkg::CFG_IDX_W-1:0]     index,
	input  logic [tlbp_pkg::CFG_DATA_W-1:0]    wdata,
	output tlbp_pkg::tlbp_cfg_t                cfg,
	output logic                               refill
);

	tlbp_pkg::tlbp_cfg_t cfg_q;

	always_comb begin
		case (index)
			tlbp_pkg::REG_HISTORY_LENGTH,
			tlbp_pkg::REG_TAG_LENGTH,
			tlbp_pkg::REG_INITIAL_COUNTER,
			tlbp_pkg::REG_SHARED_HISTORY,
			tlbp_pkg::REG_USE_GLOBAL_TABLE,
			tlbp_pkg::REG_SHARE_MODE: refill = we;
			default:                  refill = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hist_len     <= tlbp_pkg::RST_HIST_LEN;
			cfg_q.tag_len      <= tlbp_pkg::RST_TAG_LEN;
			cfg_q.init_ctr     <= tlbp_pkg::RST_INIT_CTR;
			cfg_q.hist_shared  <= tlbp_pkg::RST_HIST_SHARED;
			cfg_q.global_table <= tlbp_pkg::RST_GLOBAL_TABLE;
			cfg_q.share_mode   <= tlbp_pkg::RST_SHARE_MODE;
		end else if (we) begin
			case (index)
				tlbp_pkg::REG_HISTORY_LENGTH:
					cfg_q.hist_len <= wdata[tlbp_pkg::HLEN_W-1:0];
				tlbp_pkg::REG_TAG_LENGTH:
					cfg_q.tag_len <= wdata[tlbp_pkg::TLEN_W-1:0];
				tlbp_pkg::REG_INITIAL_COUNTER:
					cfg_q.init_ctr <= wdata[tlbp_pkg::CTR_W-1:0];
				tlbp_pkg::REG_SHARED_HISTORY:
					cfg_q.hist_shared <= wdata[0];
				tlbp_pkg::REG_USE_GLOBAL_TABLE:
					cfg_q.global_table <= wdata[0];
				tlbp_pkg::REG_SHARE_MODE:
					cfg_q.share_mode <= wdata[tlbp_pkg::SHARE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/two_level_branch_predictor_btb_core.sv]
// ----------------------------------------------------------------------------
// two_level_branch_predictor_btb_core
// Direct-mapped BTB with two-level (gshare style) direction prediction.
// In the cycle a request is taken, the entry RAM and one counter row are read;
// in the next cycle the hit, counter select and update are resolved, an
// update writes back the entry RAM and the counter row (except on a
// shared-table miss), and the result lands in the output register, visible
// the cycle after. Ready drops while a request is resolved or a held result
// blocks the next one. The counter store is one row of 2**MAX_HISTORY counters
// per entry (row 0 in shared-table mode); each row has a valid flag, so a
// configuration write or reset invalidates all rows at once and an invalid row
// reads as the initial counter value. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_btb_core #(
	parameter int BTB_ENTRIES = tlbp_pkg::DEF_BTB_ENTRIES,
	parameter int MAX_HISTORY = tlbp_pkg::DEF_MAX_HISTORY
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tlbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tlbp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	tlbp_req_if.sink                         req,
	tlbp_rsp_if.source                       rsp
);

	localparam int PC_W     = tlbp_pkg::PC_W;
	localparam int TAG_W    = tlbp_pkg::TAG_W;
	localparam int CTR_W    = tlbp_pkg::CTR_W;
	localparam int IDX_SH   = $clog2(BTB_ENTRIES);
	localparam int IDX_W    = (BTB_ENTRIES > 1) ? IDX_SH : 1;
	localparam int HW       = MAX_HISTORY;
	localparam int CTR_COLS = 1 << MAX_HISTORY;
	localparam int ROW_W    = CTR_COLS * CTR_W;
	localparam int ENT_W    = TAG_W + PC_W + HW;

	localparam logic [IDX_W-1:0]            IDX_MASK = IDX_W'(BTB_ENTRIES - 1);
	localparam logic [tlbp_pkg::HLEN_W-1:0] HIST_MAX = tlbp_pkg::HLEN_W'(MAX_HISTORY);

	tlbp_pkg::tlbp_cfg_t cfg;
	logic                refill;

	tlbp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg),
		.refill (refill)
	);

	// request side
	logic             accept;
	logic [IDX_W-1:0] req_idx;
	logic [IDX_W-1:0] req_row;

	// stage 1 (RAM data valid)
	logic             valid_s1;
	logic             op_s1;
	logic [PC_W-1:0]  pc_s1;
	logic [PC_W-1:0]  tgt_s1;
	logic             taken_s1;
	logic [PC_W-1:0]  pdst_s1;
	logic [IDX_W-1:0] row_s1;

	// state
	logic [BTB_ENTRIES-1:0] entry_valid_q;
	logic [BTB_ENTRIES-1:0] row_valid_q;
	logic [HW-1:0]          shared_hist_q;
	logic [PC_W-1:0]        branch_q;
	logic [PC_W-1:0]        flush_q;
	logic                   rsp_valid_q;
	logic                   rsp_taken_q;
	logic [PC_W-1:0]        rsp_target_q;

	// RAM ports
	logic             ent_we;
	logic [ENT_W-1:0] ent_wdata;
	logic [ENT_W-1:0] ent_rdata;
	logic             ctr_we;
	logic [ROW_W-1:0] ctr_rdata;

	// resolve logic
	logic [IDX_W-1:0]                        idx_s1;
	logic [TAG_W-1:0]                        tag_keep;
	logic [TAG_W-1:0]                        tag_cur;
	logic [TAG_W-1:0]                        ent_tag;
	logic [PC_W-1:0]                         ent_target;
	logic [HW-1:0]                           ent_hist;
	logic                                    hit;
	logic [tlbp_pkg::HLEN_W-1:0]             hist_len_eff;
	logic [HW-1:0]                           hlen_mask;
	logic [HW-1:0]                           hist_src;
	logic [HW-1:0]                           share_bits;
	logic [HW-1:0]                           ctr_col;
	logic [CTR_COLS-1:0][CTR_W-1:0]          fill_row;
	logic [CTR_COLS-1:0][CTR_W-1:0]          row_base;
	logic [CTR_COLS-1:0][CTR_W-1:0]          new_row;
	logic [CTR_COLS-1:0][CTR_W-1:0]          ctr_wrow;
	logic [CTR_W-1:0]                        ctr_cur;
	logic [CTR_W-1:0]                        ctr_next;
	logic                                    is_predict;
	logic                                    is_update;
	logic [PC_W-1:0]                         next_pc;
	logic                                    pred_taken;
	logic                                    mispredict;
	logic [HW-1:0]                           hist_base;
	logic [HW-1:0]                           ent_hist_new;
	logic [HW-1:0]                           shared_next;

	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req_idx   = IDX_W'(req.pc[PC_W-1:tlbp_pkg::ADDR_LSB]) & IDX_MASK;
	assign req_row   = cfg.global_table ? '0 : req_idx;

	tlbp_ram #(
		.WIDTH (ENT_W),
		.DEPTH (BTB_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (idx_s1),
		.wdata (ent_wdata),
		.re    (accept),
		.raddr (req_idx),
		.rdata (ent_rdata)
	);

	tlbp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BTB_ENTRIES)
	) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (row_s1),
		.wdata (ctr_wrow),
		.re    (accept),
		.raddr (req_row),
		.rdata (ctr_rdata)
	);

	assign ent_tag    = ent_rdata[ENT_W-1 -: TAG_W];
	assign ent_target = ent_rdata[HW +: PC_W];
	assign ent_hist   = ent_rdata[HW-1:0];

	assign idx_s1   = IDX_W'(pc_s1[PC_W-1:tlbp_pkg::ADDR_LSB]) & IDX_MASK;
	assign tag_keep = ~({TAG_W{1'b1}} << cfg.tag_len);
	assign tag_cur  = (pc_s1[PC_W-1:tlbp_pkg::ADDR_LSB] >> IDX_SH) & tag_keep;
	assign hit      = entry_valid_q[idx_s1] && (ent_tag == tag_cur);

	assign hist_len_eff = (cfg.hist_len > HIST_MAX) ? HIST_MAX : cfg.hist_len;
	assign hlen_mask    = ~({HW{1'b1}} << hist_len_eff);
	assign hist_src     = cfg.hist_shared ? shared_hist_q : ent_hist;

	always_comb begin
		case (cfg.share_mode)
			tlbp_pkg::SHR_PC_LO: share_bits = pc_s1[tlbp_pkg::XOR_LO_BIT +: HW];
			tlbp_pkg::SHR_PC_HI: share_bits = pc_s1[tlbp_pkg::XOR_HI_BIT +: HW];
			default:             share_bits = '0;
		endcase
	end

	assign ctr_col  = (hist_src ^ share_bits) & hlen_mask;
	assign fill_row = {CTR_COLS{cfg.init_ctr}};
	assign row_base = row_valid_q[row_s1] ? ctr_rdata : fill_row;
	assign ctr_cur  = row_base[ctr_col];

	always_comb begin
		if (taken_s1) begin
			ctr_next = (ctr_cur == tlbp_pkg::CTR_MAX) ? ctr_cur : ctr_cur + 1'b1;
		end else begin
			ctr_next = (ctr_cur == tlbp_pkg::CTR_MIN) ? ctr_cur : ctr_cur - 1'b1;
		end
	end

	always_comb begin
		for (int c = 0; c < CTR_COLS; c++) begin
			new_row[c] = (HW'(c) == ctr_col) ? ctr_next : row_base[c];
		end
	end

	assign is_predict = valid_s1 && (op_s1 == tlbp_pkg::OP_PREDICT);
	assign is_update  = valid_s1 && (op_s1 == tlbp_pkg::OP_UPDATE);
	assign next_pc    = pc_s1 + PC_W'(tlbp_pkg::PC_STEP);
	assign pred_taken = hit && (ctr_cur >= tlbp_pkg::CTR_WEAK_TAKEN);
	assign mispredict = ((pdst_s1 != next_pc) != taken_s1);

	// a fresh entry starts from an empty history
	assign hist_base    = hit ? ent_hist : '0;
	assign ent_hist_new = cfg.hist_shared ? hist_base
	                                      : ((hist_base << 1) | HW'(taken_s1)) & hlen_mask;
	assign shared_next  = ((shared_hist_q << 1) | HW'(taken_s1)) & hlen_mask;

	assign ent_we    = is_update;
	assign ent_wdata = {tag_cur, tgt_s1, ent_hist_new};
	assign ctr_we    = is_update && (hit || !cfg.global_table);
	assign ctr_wrow  = hit ? new_row : fill_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			entry_valid_q <= '0;
			row_valid_q   <= '0;
			shared_hist_q <= '0;
			branch_q      <= '0;
			flush_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (is_predict) begin
				branch_q <= branch_q + 1'b1;
			end
			if (is_update && mispredict) begin
				flush_q <= flush_q + 1'b1;
			end
			if (is_update) begin
				entry_valid_q[idx_s1] <= 1'b1;
				if (cfg.hist_shared) begin
					shared_hist_q <= shared_next;
				end
			end
			if (refill) begin
				row_valid_q <= '0;
			end else if (ctr_we) begin
				row_valid_q[row_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req.operation;
			pc_s1    <= req.pc;
			tgt_s1   <= req.target_pc;
			taken_s1 <= req.taken;
			pdst_s1  <= req.predicted_dest;
			row_s1   <= req_row;
		end
		if (valid_s1) begin
			rsp_taken_q <= is_predict && pred_taken;
			if (is_predict) begin
				rsp_target_q <= pred_taken ? ent_target : next_pc;
			end else begin
				rsp_target_q <= '0;
			end
		end
	end

	// counts only move when a result is loaded, and a loaded result holds
	// them until taken
	assign rsp.valid            = rsp_valid_q;
	assign rsp.predicted_taken  = rsp_taken_q;
	assign rsp.predicted_target = rsp_target_q;
	assign rsp.branch_count     = branch_q;
	assign rsp.flush_count      = flush_q;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !rsp_valid_q)
		else $error("result register busy while resolving a request");

	a_one_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> !valid_s1)
		else $error("back-to-back resolve cycles");

	a_refill_clears: assert property (@(posedge clk) disable iff (!arst_n)
		refill |=> (row_valid_q == '0))
		else $error("counter rows still valid after refill");

	a_flush_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && (op_s1 == tlbp_pkg::OP_UPDATE)) |=> $stable(flush_q))
		else $error("flush count moved without an update");

	a_branch_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && (op_s1 == tlbp_pkg::OP_PREDICT)) |=> $stable(branch_q))
		else $error("branch count moved without a predict");

endmodule

[tb/two_level_branch_predictor_btb_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_branch_predictor_btb_check
// Watches the request, result and register ports of the predictor. It keeps
// its own copy of the BTB, the histories and the counter store. For every
// accepted request it queues the expected result, and it compares every
// accepted result field by field with the oldest entry in that queue.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_btb_check import tlbp_pkg::*; #(
	parameter int BTB_ENTRIES = DEF_BTB_ENTRIES,
	parameter int MAX_HISTORY = DEF_MAX_HISTORY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	tlbp_req_if                   req,
	tlbp_rsp_if                   rsp,
	output int                    errors,
	output int                    pending,
	output int                    compared
);

	localparam int IDX_W     = $clog2(BTB_ENTRIES);
	localparam int CTR_DEPTH = BTB_ENTRIES << MAX_HISTORY;

	typedef struct packed {
		logic            taken;
		logic [PC_W-1:0] target;
		logic [PC_W-1:0] branches;
		logic [PC_W-1:0] flushes;
	} prediction_t;

	tlbp_cfg_t              cfg;
	logic                   ent_valid  [BTB_ENTRIES];
	logic [TAG_W-1:0]       ent_tag    [BTB_ENTRIES];
	logic [PC_W-1:0]        ent_target [BTB_ENTRIES];
	logic [MAX_HISTORY-1:0] ent_hist   [BTB_ENTRIES];
	logic [MAX_HISTORY-1:0] shared_hist;
	logic [CTR_W-1:0]       ctr        [CTR_DEPTH];
	logic [PC_W-1:0]        n_branches;
	logic [PC_W-1:0]        n_flushes;
	prediction_t            expected_results[$];
	int                     mismatches;
	int                     n_compared;

	function automatic int hist_bits();
		return (cfg.hist_len > MAX_HISTORY) ? MAX_HISTORY : int'(cfg.hist_len);
	endfunction

	function automatic void refill_counters();
		for (int i = 0; i < CTR_DEPTH; i++)
			ctr[i] = cfg.init_ctr;
	endfunction

	function automatic void clear_model();
		cfg = '{RST_HIST_LEN, RST_TAG_LEN, RST_INIT_CTR, RST_HIST_SHARED,
			RST_GLOBAL_TABLE, RST_SHARE_MODE};
		for (int i = 0; i < BTB_ENTRIES; i++) begin
			ent_valid[i]  = 1'b0;
			ent_tag[i]    = '0;
			ent_target[i] = '0;
			ent_hist[i]   = '0;
		end
		shared_hist = '0;
		n_branches  = '0;
		n_flushes   = '0;
		refill_counters();
	endfunction

	function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] d);
		case (idx)
		REG_HISTORY_LENGTH:   cfg.hist_len     = d[HLEN_W-1:0];
		REG_TAG_LENGTH:       cfg.tag_len      = d[TLEN_W-1:0];
		REG_INITIAL_COUNTER:  cfg.init_ctr     = d[CTR_W-1:0];
		REG_SHARED_HISTORY:   cfg.hist_shared  = d[0];
		REG_USE_GLOBAL_TABLE: cfg.global_table = d[0];
		REG_SHARE_MODE:       cfg.share_mode   = d[SHARE_W-1:0];
		default: return;
		endcase
		refill_counters();
	endfunction

	function automatic int entry_of(logic [PC_W-1:0] pc);
		return int'((pc >> ADDR_LSB) & (BTB_ENTRIES - 1));
	endfunction

	function automatic logic [TAG_W-1:0] tag_of(logic [PC_W-1:0] pc);
		logic [63:0] mask;
		mask = (64'd1 << cfg.tag_len) - 64'd1;
		return TAG_W'(((64'(pc) >> ADDR_LSB) >> IDX_W) & mask);
	endfunction

	function automatic int unsigned counter_slot(logic [PC_W-1:0] pc, int e);
		int          hl;
		int unsigned hmask;
		int unsigned h;
		hl    = hist_bits();
		hmask = (32'd1 << hl) - 32'd1;
		h     = cfg.hist_shared ? 32'(shared_hist) : 32'(ent_hist[e]);
		h     = h & hmask;
		if (cfg.share_mode == SHR_PC_LO)
			h = h ^ ((pc >> XOR_LO_BIT) & hmask);
		else if (cfg.share_mode == SHR_PC_HI)
			h = h ^ ((pc >> XOR_HI_BIT) & hmask);
		if (cfg.global_table)
			return h;
		return ((32'(e) << hl) + h) % CTR_DEPTH;
	endfunction

	function automatic prediction_t resolve_request(tlbp_op_t op, logic [PC_W-1:0] pc,
			logic [PC_W-1:0] tgt, logic tk, logic [PC_W-1:0] pdst);
		prediction_t      p;
		int               e;
		int               hl;
		int unsigned      hmask;
		int unsigned      s;
		logic [TAG_W-1:0] t;
		logic             hit;
		logic [PC_W-1:0]  nxt;
		e     = entry_of(pc);
		t     = tag_of(pc);
		hit   = ent_valid[e] && (ent_tag[e] == t);
		nxt   = pc + PC_STEP;
		hl    = hist_bits();
		hmask = (32'd1 << hl) - 32'd1;
		p     = '0;
		if (op == OP_PREDICT) begin
			p.target = nxt;
			if (hit) begin
				s = counter_slot(pc, e);
				if (ctr[s] >= CTR_WEAK_TAKEN) begin
					p.taken  = 1'b1;
					p.target = ent_target[e];
				end
			end
			n_branches = n_branches + 1'b1;
		end else begin
			if ((pdst != nxt) != tk)
				n_flushes = n_flushes + 1'b1;
			if (!hit) begin
				ent_valid[e]  = 1'b1;
				ent_tag[e]    = t;
				ent_target[e] = tgt;
				ent_hist[e]   = '0;
				if (!cfg.global_table)
					for (int j = 0; j < (1 << hl); j++)
						ctr[(e << hl) + j] = cfg.init_ctr;
			end else begin
				s = counter_slot(pc, e);
				if (tk) begin
					if (ctr[s] != CTR_MAX)
						ctr[s] = ctr[s] + 1'b1;
				end else if (ctr[s] != CTR_MIN) begin
					ctr[s] = ctr[s] - 1'b1;
				end
				ent_target[e] = tgt;
			end
			if (cfg.hist_shared)
				shared_hist = MAX_HISTORY'(((32'(shared_hist) << 1) | tk) & hmask);
			else
				ent_hist[e] = MAX_HISTORY'(((32'(ent_hist[e]) << 1) | tk) & hmask);
		end
		p.branches = n_branches;
		p.flushes  = n_flushes;
		return p;
	endfunction

	function automatic void check_result();
		prediction_t want;
		if (expected_results.size() == 0) begin
			$error("result arrived with no request outstanding");
			mismatches++;
			return;
		end
		want = expected_results.pop_front();
		n_compared++;
		if (rsp.predicted_taken !== want.taken) begin
			$error("predicted_taken: expected %0d, got %0d", want.taken, rsp.predicted_taken);
			mismatches++;
		end
		if (rsp.predicted_target !== want.target) begin
			$error("predicted_target: expected %h, got %h", want.target, rsp.predicted_target);
			mismatches++;
		end
		if (rsp.branch_count !== want.branches) begin
			$error("branch_count: expected %0d, got %0d", want.branches, rsp.branch_count);
			mismatches++;
		end
		if (rsp.flush_count !== want.flushes) begin
			$error("flush_count: expected %0d, got %0d", want.flushes, rsp.flush_count);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			expected_results.delete();
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (cfg_we)
				write_register(cfg_index, cfg_wdata);
			if (req.valid && req.ready)
				expected_results.push_back(resolve_request(tlbp_op_t'(req.operation),
					req.pc, req.target_pc, req.taken, req.predicted_dest));
		end
		errors   <= mismatches;
		pending  <= expected_results.size();
		compared <= n_compared;
	end

endmodule

[tb/two_level_branch_predictor_btb_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_branch_predictor_btb_core_tb
// Drives predict and update requests into the BTB predictor under seven
// register settings, with random gaps on both channels and one long result
// stall. A short directed run covers address extremes, allocation, eviction
// and counter saturation; the rest is mostly predict/update loops over a small
// pool of aliasing branches plus random noise. The checker does the scoring.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_btb_core_tb;
	import tlbp_pkg::*;

	localparam int LIMIT       = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AFTER  = 100;
	localparam int PHASE_ITEMS = 70;
	localparam int PHASES      = 7;
	localparam int POOL        = 16;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef enum int {ALWAYS_TAKEN, NEVER_TAKEN, ALTERNATING, RANDOM_OUTCOME} outcome_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int  errors;
	int  pending;
	int  compared;
	int  cycles;
	int  sent;
	int  delivered;
	bit  steady;
	logic [PC_W-1:0] pc_pool  [POOL];
	logic [PC_W-1:0] tgt_pool [POOL];

	tlbp_req_if req ();
	tlbp_rsp_if rsp ();

	two_level_branch_predictor_btb_core #(
		.BTB_ENTRIES (DEF_BTB_ENTRIES),
		.MAX_HISTORY (DEF_MAX_HISTORY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	two_level_branch_predictor_btb_check #(
		.BTB_ENTRIES (DEF_BTB_ENTRIES),
		.MAX_HISTORY (DEF_MAX_HISTORY)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending),
		.compared  (compared)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random back-pressure, one long hold once traffic is flowing
	initial begin
		int  n;
		bit  held;
		held      = 1'b0;
		delivered = 0;
		rsp.ready = 1'b0;
		n         = 0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				delivered++;
			if (!held && delivered >= HOLD_AFTER) begin
				held = 1'b1;
				n    = LONG_HOLD;
			end
			if (n > 0) begin
				n--;
				rsp.ready <= 1'b0;
			end else if (steady || $urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b1;
			end else begin
				n = idle_len();
				rsp.ready <= (n == 0);
				if (n > 0)
					n--;
			end
		end
	end

	task automatic issue(tlbp_op_t op, logic [PC_W-1:0] pc, logic [PC_W-1:0] tgt,
			logic tk, logic [PC_W-1:0] pdst);
		int gap;
		req.valid          <= 1'b1;
		req.operation      <= op;
		req.pc             <= pc;
		req.target_pc      <= tgt;
		req.taken          <= tk;
		req.predicted_dest <= pdst;
		do
			@(posedge clk);
		while (!req.ready);
		sent++;
		gap = idle_len();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_phase(int ph);
		logic [CFG_DATA_W-1:0] v [6];
		case (ph)
		1: v = '{5'd1,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1};
		2: v = '{5'd15, 5'd31, 5'd3,  5'd0,  5'd1,  5'd2};
		3: v = '{5'd0,  5'd25, 5'd2,  5'd31, 5'd0,  5'd3};
		4: v = '{5'd4,  5'd3,  5'd3,  5'd0,  5'd30, 5'd1};
		5: v = '{5'd8,  5'd12, 5'd28, 5'd1,  5'd1,  5'd2};
		default: foreach (v[i]) v[i] = CFG_DATA_W'($urandom);
		endcase
		write_reg(REG_HISTORY_LENGTH,   v[0]);
		write_reg(REG_TAG_LENGTH,       v[1]);
		write_reg(REG_INITIAL_COUNTER,  v[2]);
		write_reg(REG_SHARED_HISTORY,   v[3]);
		write_reg(REG_USE_GLOBAL_TABLE, v[4]);
		write_reg(REG_SHARE_MODE,       v[5]);
		if (ph == 3 || ph == PHASES - 1) begin
			write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
			write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));
		end
	endtask

	task automatic directed_items();
		issue(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
		issue(OP_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		issue(OP_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0004);
		// long taken run fills the history and saturates one counter
		for (int k = 0; k < 10; k++)
			issue(OP_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		issue(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
		issue(OP_UPDATE,  32'h0000_0000, 32'h1234_5678, 1'b0, 32'h0000_0000);
		// same entry, other tag: eviction
		issue(OP_UPDATE,  32'h0000_0080, 32'h0000_0100, 1'b1, 32'h0000_0084);
		issue(OP_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
		issue(OP_UPDATE,  32'hFFFF_FFFC, 32'h8000_0000, 1'b0, 32'h0000_0000);
		issue(OP_PREDICT, 32'hFFFF_FFFC, 32'h0000_0000, 1'b0, 32'h0000_0000);
		issue(OP_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0003);
		issue(OP_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0000);
	endtask

	task automatic run_loop();
		int              s;
		int              reps;
		outcome_style_t  style;
		logic [PC_W-1:0] pc;
		logic [PC_W-1:0] tgt;
		logic [PC_W-1:0] pdst;
		logic            tk;
		s     = $urandom_range(0, POOL - 1);
		reps  = $urandom_range(1, 6);
		style = outcome_style_t'($urandom_range(0, 3));
		pc    = pc_pool[s];
		for (int k = 0; k < reps; k++) begin
			case (style)
			ALWAYS_TAKEN: tk = 1'b1;
			NEVER_TAKEN:  tk = 1'b0;
			ALTERNATING:  tk = k[0];
			default:      tk = 1'($urandom);
			endcase
			tgt = ($urandom_range(0, 9) == 0) ? PC_W'($urandom) : tgt_pool[s];
			if ($urandom_range(0, 6) != 0)
				issue(OP_PREDICT, pc, '0, 1'b0, '0);
			pdst = tk ? tgt_pool[s] : pc + PC_STEP;
			if ($urandom_range(0, 3) == 0)
				pdst = tk ? pc + PC_STEP : tgt;
			issue(OP_UPDATE, pc, tgt, tk, pdst);
			tgt_pool[s] = tgt;
		end
	endtask

	task automatic random_items(int n);
		int start;
		start = sent;
		while (sent - start < n) begin
			if ($urandom_range(0, 4) == 0)
				issue(tlbp_op_t'($urandom_range(0, 1)), PC_W'($urandom), PC_W'($urandom),
					1'($urandom), PC_W'($urandom));
			else
				run_loop();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		req.valid          = 1'b0;
		req.operation      = OP_PREDICT;
		req.pc             = '0;
		req.target_pc      = '0;
		req.taken          = 1'b0;
		req.predicted_dest = '0;
		sent               = 0;
		steady             = 1'b0;
		for (int i = 0; i < POOL; i++) begin
			pc_pool[i]      = PC_W'($urandom);
			pc_pool[i][6:2] = 5'(i % 6);
			pc_pool[i][1:0] = 2'b00;
			tgt_pool[i]     = PC_W'($urandom);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		random_items(PHASE_ITEMS);
		for (int ph = 1; ph < PHASES; ph++) begin
			drain();
			set_phase(ph);
			steady = (ph == 2 || ph == 4);
			random_items(PHASE_ITEMS);
		end
		steady = 1'b0;
		drain();
		repeat (8) @(posedge clk);
		$display("Summary: %0d requests sent, %0d results compared across %0d register settings,",
			sent, compared, PHASES);
		$display("         with random gaps on both channels and one long result hold-off.");
		if (errors == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
